// File: sv/vie_pkg.sv
`timescale 1ns / 1ps
package vie_pkg;

	localparam int PC_W              = 12;
	localparam int IDX_W             = 16;
	localparam int REG_W             = 8;
	localparam int RN_W              = 4;
	localparam int NUM_REGS          = 16;
	localparam int WORD_W            = 16;
	localparam int KEYS_W            = 16;
	localparam int STACK_ENTRIES_DEF = 16;

	localparam logic [PC_W-1:0]   RESET_PC  = 12'd512;
	localparam logic [RN_W-1:0]   FLAG_REG  = 4'hF;
	localparam logic [IDX_W-1:0]  FONT_BASE = 16'd80;
	localparam logic [WORD_W-1:0] RET_WORD  = 16'h00EE;

	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SE   = 4'h3;
	localparam logic [3:0] OP_SNE  = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LD   = 4'h6;
	localparam logic [3:0] OP_ADD  = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_JPO  = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP   = 8'hA1;

	localparam logic [7:0] F_GET_DT = 8'h07;
	localparam logic [7:0] F_SET_DT = 8'h15;
	localparam logic [7:0] F_SET_ST = 8'h18;
	localparam logic [7:0] F_ADD_I  = 8'h1E;
	localparam logic [7:0] F_FONT   = 8'h29;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_UNSUPPORTED = 2'd1,
		ST_STACK       = 2'd2
	} status_t;

	typedef struct packed {
		logic [PC_W-1:0]  pc;
		logic [PC_W-1:0]  link;
		logic [IDX_W-1:0] idx;
		logic             wr_en;
		logic [RN_W-1:0]  wr_addr;
		logic [REG_W-1:0] wr_data;
		logic             fl_en;
		logic [REG_W-1:0] fl_data;
		logic             push;
		logic             pop;
		logic             dt_we;
		status_t          status;
	} exec_t;

endpackage

// File: sv/vie_ifs.sv
`timescale 1ns / 1ps
interface vie_in_if;
	logic                          valid;
	logic                          ready;
	logic [vie_pkg::WORD_W-1:0]    instr_word;
	logic [vie_pkg::REG_W-1:0]     random_byte;
	logic [vie_pkg::KEYS_W-1:0]    keys_down;

	modport source (output valid, instr_word, random_byte, keys_down, input ready);
	modport sink (input valid, instr_word, random_byte, keys_down, output ready);
endinterface

interface vie_out_if;
	logic                       valid;
	logic                       ready;
	logic [vie_pkg::PC_W-1:0]   next_pc;
	logic [vie_pkg::IDX_W-1:0]  index_value;
	logic                       wrote_reg;
	logic [vie_pkg::RN_W-1:0]   reg_number;
	logic [vie_pkg::REG_W-1:0]  reg_value;
	logic [vie_pkg::REG_W-1:0]  flag_value;
	vie_pkg::status_t           status;

	modport source (output valid, next_pc, index_value, wrote_reg, reg_number, reg_value,
		flag_value, status, input ready);
	modport sink (input valid, next_pc, index_value, wrote_reg, reg_number, reg_value,
		flag_value, status, output ready);
endinterface

// File: sv/vie_regfile.sv
`timescale 1ns / 1ps
module vie_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [vie_pkg::RN_W-1:0]   rd_addr_a,
	input  logic [vie_pkg::RN_W-1:0]   rd_addr_b,
	input  logic                       wr_en,
	input  logic [vie_pkg::RN_W-1:0]   wr_addr,
	input  logic [vie_pkg::REG_W-1:0]  wr_data,
	output logic [vie_pkg::REG_W-1:0]  rd_data_a,
	output logic [vie_pkg::REG_W-1:0]  rd_data_b
);
	import vie_pkg::*;

	logic [REG_W-1:0]    mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [REG_W-1:0]    ma_q, mb_q;
	logic                va_q, vb_q;
	logic [RN_W-1:0]     ra_q, rb_q;
	logic                fwd_vld_q;
	logic [RN_W-1:0]     fwd_addr_q;
	logic [REG_W-1:0]    fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ma_q <= mem[rd_addr_a];
			mb_q <= mem[rd_addr_b];
			va_q <= vld_q[rd_addr_a];
			vb_q <= vld_q[rd_addr_b];
			ra_q <= rd_addr_a;
			rb_q <= rd_addr_b;
		end
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			fwd_vld_q <= 1'b0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
			fwd_vld_q      <= 1'b1;
		end
	end

	// last write may land on the edge of the read
	assign rd_data_a = (fwd_vld_q && fwd_addr_q == ra_q) ? fwd_data_q : (va_q ? ma_q : '0);
	assign rd_data_b = (fwd_vld_q && fwd_addr_q == rb_q) ? fwd_data_q : (vb_q ? mb_q : '0);

endmodule

// File: sv/vie_stack.sv
`timescale 1ns / 1ps
module vie_stack #(
	parameter int ENTRIES = vie_pkg::STACK_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
	input  logic                         wr_en,
	input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
	input  logic [vie_pkg::PC_W-1:0]     wr_data,
	output logic [vie_pkg::PC_W-1:0]     rd_data
);
	import vie_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	logic [PC_W-1:0] mem [ENTRIES];
	logic [PC_W-1:0] rd_q;
	logic [AW-1:0]   ra_q;
	logic            fwd_vld_q;
	logic [AW-1:0]   fwd_addr_q;
	logic [PC_W-1:0] fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
			fwd_addr_q   <= wr_addr;
			fwd_data_q   <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
			ra_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (wr_en) begin
			fwd_vld_q <= 1'b1;
		end
	end

	assign rd_data = (fwd_vld_q && fwd_addr_q == ra_q) ? fwd_data_q : rd_q;

endmodule

// File: sv/vie_exec.sv
`timescale 1ns / 1ps
module vie_exec (
	input  logic [vie_pkg::WORD_W-1:0] instr_word,
	input  logic [vie_pkg::REG_W-1:0]  random_byte,
	input  logic [vie_pkg::KEYS_W-1:0] keys_down,
	input  logic [vie_pkg::REG_W-1:0]  vx,
	input  logic [vie_pkg::REG_W-1:0]  vy,
	input  logic [vie_pkg::PC_W-1:0]   pc,
	input  logic [vie_pkg::IDX_W-1:0]  idx,
	input  logic [vie_pkg::REG_W-1:0]  dt,
	input  logic [vie_pkg::PC_W-1:0]   stk_top,
	input  logic                       stk_full,
	input  logic                       stk_empty,
	output vie_pkg::exec_t             ex
);
	import vie_pkg::*;

	logic [3:0]       op, n;
	logic [RN_W-1:0]  x;
	logic [7:0]       nn;
	logic [PC_W-1:0]  nnn, pc2, pc4;
	logic [REG_W:0]   add9;
	logic [IDX_W:0]   idx_sum;
	logic [IDX_W-1:0] font;
	logic             key;

	assign op      = instr_word[15:12];
	assign x       = instr_word[11:8];
	assign n       = instr_word[3:0];
	assign nn      = instr_word[7:0];
	assign nnn     = instr_word[11:0];
	assign pc2     = pc + PC_W'(2);
	assign pc4     = pc + PC_W'(4);
	assign add9    = {1'b0, vx} + {1'b0, vy};
	assign idx_sum = {1'b0, idx} + (IDX_W + 1)'(vx);
	assign font    = FONT_BASE + IDX_W'({vx, 2'b00}) + IDX_W'(vx);
	assign key     = keys_down[vx[3:0]];

	always_comb begin
		ex         = '0;
		ex.pc      = pc2;
		ex.link    = pc2;
		ex.idx     = idx;
		ex.wr_addr = x;
		ex.status  = ST_OK;
		unique case (op)
			OP_SYS: begin
				if (instr_word == RET_WORD) begin
					if (stk_empty) begin
						ex.status = ST_STACK;
					end else begin
						ex.pop = 1'b1;
						ex.pc  = stk_top;
					end
				end else begin
					ex.status = ST_UNSUPPORTED;
				end
			end
			OP_JP: ex.pc = nnn;
			OP_CALL: begin
				if (stk_full) begin
					ex.status = ST_STACK;
				end else begin
					ex.push = 1'b1;
					ex.pc   = nnn;
				end
			end
			OP_SE: if (vx == nn) ex.pc = pc4;
			OP_SNE: if (vx != nn) ex.pc = pc4;
			OP_SER: begin
				if (n != 4'h0) ex.status = ST_UNSUPPORTED;
				else if (vx == vy) ex.pc = pc4;
			end
			OP_LD: begin
				ex.wr_en   = 1'b1;
				ex.wr_data = nn;
			end
			OP_ADD: begin
				ex.wr_en   = 1'b1;
				ex.wr_data = vx + nn;
			end
			OP_ALU: begin
				ex.wr_en = 1'b1;
				unique case (n)
					ALU_MOV: ex.wr_data = vy;
					ALU_OR:  ex.wr_data = vx | vy;
					ALU_AND: ex.wr_data = vx & vy;
					ALU_XOR: ex.wr_data = vx ^ vy;
					ALU_ADD: begin
						ex.fl_en   = 1'b1;
						ex.fl_data = REG_W'(add9[REG_W]);
						ex.wr_data = add9[REG_W-1:0];
					end
					ALU_SUB: begin
						ex.fl_en   = 1'b1;
						ex.fl_data = REG_W'(vx >= vy);
						ex.wr_data = vx - vy;
					end
					ALU_SHR: begin
						ex.fl_en   = 1'b1;
						ex.fl_data = REG_W'(vy[0]);
						ex.wr_data = vy >> 1;
					end
					ALU_SUBN: begin
						ex.fl_en   = 1'b1;
						ex.fl_data = REG_W'(vy >= vx);
						ex.wr_data = vy - vx;
					end
					ALU_SHL: begin
						ex.fl_en   = 1'b1;
						ex.fl_data = REG_W'(vy[REG_W-1]);
						ex.wr_data = vy << 1;
					end
					default: begin
						ex.wr_en  = 1'b0;
						ex.status = ST_UNSUPPORTED;
					end
				endcase
			end
			OP_SNER: begin
				if (n != 4'h0) ex.status = ST_UNSUPPORTED;
				else if (vx != vy) ex.pc = pc4;
			end
			OP_LDI: ex.idx = IDX_W'(nnn);
			OP_JPO: ex.pc = nnn + PC_W'(vx);
			OP_RND: begin
				ex.wr_en   = 1'b1;
				ex.wr_data = random_byte & nn;
			end
			OP_KEY: begin
				if (nn == KEY_DOWN) begin
					if (key) ex.pc = pc4;
				end else if (nn == KEY_UP) begin
					if (!key) ex.pc = pc4;
				end else begin
					ex.status = ST_UNSUPPORTED;
				end
			end
			OP_MISC: begin
				unique case (nn)
					F_GET_DT: begin
						ex.wr_en   = 1'b1;
						ex.wr_data = dt;
					end
					F_SET_DT: ex.dt_we = 1'b1;
					// sound timer has no readable path
					F_SET_ST: ex.status = ST_OK;
					F_ADD_I: begin
						ex.idx     = idx_sum[IDX_W-1:0];
						ex.wr_en   = (idx_sum[IDX_W:12] != '0);
						ex.wr_addr = FLAG_REG;
						ex.wr_data = REG_W'(1);
					end
					F_FONT: ex.idx = font;
					default: ex.status = ST_UNSUPPORTED;
				endcase
			end
			default: ex.status = ST_UNSUPPORTED;
		endcase
	end

endmodule

// File: sv/vm_instruction_execute_unit.sv
`timescale 1ns / 1ps
// channel   dir  fields
// instr     in   instr_word, random_byte, keys_down
// result    out  next_pc, index_value, wrote_reg, reg_number, reg_value, flag_value, status
// cfg_wr_*  in   start_address, also loads the program counter
//
// one instruction per cycle unless the result channel stalls; each result is registered
// the read stage reads the register and stack memories, the execute stage executes and writes back
// reset: registers zero, pc 512, empty stack, no clearing pass
// a stalled result register holds the execute stage; requests keep flowing once it drains
module vm_instruction_execute_unit #(
	parameter int STACK_ENTRIES = vie_pkg::STACK_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [vie_pkg::PC_W-1:0]  cfg_wr_data,
	vie_in_if.sink                    instr,
	vie_out_if.source                 result
);
	import vie_pkg::*;

	localparam int SA_W = $clog2(STACK_ENTRIES);
	localparam int SD_W = $clog2(STACK_ENTRIES + 1);
	localparam logic [SD_W-1:0] SD_FULL = SD_W'(STACK_ENTRIES);

	logic              v_s1, v_s2;
	logic [WORD_W-1:0] instr_s1;
	logic [REG_W-1:0]  rnd_s1;
	logic [KEYS_W-1:0] keys_s1;
	logic [PC_W-1:0]   pc_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SD_W-1:0]   depth_q, depth_next, depth_d;
	logic [REG_W-1:0]  dt_q, vf_q, vf_next;
	logic              acc, adv1;
	logic [REG_W-1:0]  rf_x, rf_y, vx, vy;
	logic [PC_W-1:0]   stk_top;
	logic              rf_we;
	exec_t             ex;

	logic [PC_W-1:0]   pc_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic              wrote_s2;
	logic [RN_W-1:0]   rn_s2;
	logic [REG_W-1:0]  rv_s2, fv_s2;
	status_t           st_s2;

	assign adv1        = v_s1 && (!v_s2 || result.ready);
	assign instr.ready = !v_s1 || adv1;
	assign acc         = instr.valid && instr.ready;

	vie_regfile u_rf (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (acc),
		.rd_addr_a (instr.instr_word[11:8]),
		.rd_addr_b (instr.instr_word[7:4]),
		.wr_en     (rf_we),
		.wr_addr   (ex.wr_addr),
		.wr_data   (ex.wr_data),
		.rd_data_a (rf_x),
		.rd_data_b (rf_y)
	);

	// flag register lives outside the memory
	assign vx    = (instr_s1[11:8] == FLAG_REG) ? vf_q : rf_x;
	assign vy    = (instr_s1[7:4] == FLAG_REG) ? vf_q : rf_y;
	assign rf_we = adv1 && ex.wr_en && (ex.wr_addr != FLAG_REG);

	assign depth_next = ex.push ? depth_q + SD_W'(1) : (ex.pop ? depth_q - SD_W'(1) : depth_q);
	assign depth_d    = adv1 ? depth_next : depth_q;

	vie_stack #(.ENTRIES(STACK_ENTRIES)) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (SA_W'(depth_d - SD_W'(1))),
		.wr_en   (adv1 && ex.push),
		.wr_addr (depth_q[SA_W-1:0]),
		.wr_data (ex.link),
		.rd_data (stk_top)
	);

	vie_exec u_exec (
		.instr_word  (instr_s1),
		.random_byte (rnd_s1),
		.keys_down   (keys_s1),
		.vx          (vx),
		.vy          (vy),
		.pc          (pc_q),
		.idx         (idx_q),
		.dt          (dt_q),
		.stk_top     (stk_top),
		.stk_full    (depth_q >= SD_FULL),
		.stk_empty   (depth_q == '0),
		.ex          (ex)
	);

	assign vf_next = (ex.wr_en && ex.wr_addr == FLAG_REG) ? ex.wr_data :
		(ex.fl_en ? ex.fl_data : vf_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			pc_q    <= RESET_PC;
			idx_q   <= '0;
			depth_q <= '0;
			dt_q    <= '0;
			vf_q    <= '0;
		end else begin
			if (instr.ready) begin
				v_s1 <= instr.valid;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
			if (cfg_wr_en) begin
				pc_q <= cfg_wr_data;
			end else if (adv1) begin
				pc_q <= ex.pc;
			end
			if (adv1) begin
				idx_q   <= ex.idx;
				depth_q <= depth_next;
				vf_q    <= vf_next;
				if (ex.dt_we) begin
					dt_q <= vx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			instr_s1 <= instr.instr_word;
			rnd_s1   <= instr.random_byte;
			keys_s1  <= instr.keys_down;
		end
		if (adv1) begin
			pc_s2    <= ex.pc;
			idx_s2   <= ex.idx;
			wrote_s2 <= ex.wr_en;
			rn_s2    <= ex.wr_en ? ex.wr_addr : '0;
			rv_s2    <= ex.wr_en ? ex.wr_data : '0;
			fv_s2    <= vf_next;
			st_s2    <= ex.status;
		end
	end

	assign result.valid       = v_s2;
	assign result.next_pc     = pc_s2;
	assign result.index_value = idx_s2;
	assign result.wrote_reg   = wrote_s2;
	assign result.reg_number  = rn_s2;
	assign result.reg_value   = rv_s2;
	assign result.flag_value  = fv_s2;
	assign result.status      = st_s2;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= SD_FULL)
		else $error("stack depth beyond capacity");

	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && ex.push |=> depth_q == $past(depth_q) + SD_W'(1))
		else $error("push did not grow stack");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted request lost before execute");

	a_no_flag_mem: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> ex.wr_addr != FLAG_REG)
		else $error("flag register written into memory");

endmodule

// File: tb/sv/vm_instruction_execute_unit_tb.sv
`timescale 1ns / 1ps
module vm_instruction_execute_unit_tb;
	import vie_pkg::*;

	localparam int STACK_SLOTS    = STACK_ENTRIES_DEF;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int NUM_DIRECTED   = 31;

	localparam logic [3:0] ALU_CODES [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
		ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL};
	localparam logic [7:0] MISC_CODES [5] = '{F_GET_DT, F_SET_DT, F_SET_ST, F_ADD_I, F_FONT};

	typedef struct packed {
		logic [WORD_W-1:0] instr_word;
		logic [REG_W-1:0]  random_byte;
		logic [KEYS_W-1:0] keys_down;
	} instr_req_t;

	typedef struct packed {
		logic [PC_W-1:0]  next_pc;
		logic [IDX_W-1:0] index_value;
		logic             wrote_reg;
		logic [RN_W-1:0]  reg_number;
		logic [REG_W-1:0] reg_value;
		logic [REG_W-1:0] flag_value;
		status_t          status;
	} exec_result_t;

	typedef struct packed {
		instr_req_t   req;
		logic         typed;
		exec_result_t want;
	} directed_row_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [PC_W-1:0] cfg_wr_data;

	vie_in_if  instr_ch();
	vie_out_if result_ch();

	vm_instruction_execute_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.instr       (instr_ch),
		.result      (result_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// machine state as the block should hold it
	logic [REG_W-1:0] vregs [NUM_REGS];
	logic [PC_W-1:0]  cur_pc;
	logic [IDX_W-1:0] index_reg;
	logic [PC_W-1:0]  return_stack [STACK_SLOTS];
	int               stack_level;
	logic [REG_W-1:0] delay_count;

	exec_result_t expected_results [$];
	int           error_count = 0;
	int           quiet_cycles = 0;
	int           burst_left = 0;
	int           stall_left = 0;
	int           stall_mode = 0;
	int           mode_left = 0;
	int           run_calls = 0;
	int           run_returns = 0;

	directed_row_t directed_rows [0:NUM_DIRECTED-1] = '{
		'{'{RET_WORD, 8'h00, 16'h0000}, 1'b1,
			'{12'd514, 16'd0, 1'b0, 4'd0, 8'h00, 8'h00, ST_STACK}},
		'{'{{OP_LD, 4'h0, 8'hFF}, 8'h00, 16'hFFFF}, 1'b1,
			'{12'd516, 16'd0, 1'b1, 4'd0, 8'hFF, 8'h00, ST_OK}},
		'{'{{OP_ALU, 4'h0, 4'h0, ALU_ADD}, 8'h00, 16'h0000}, 1'b1,
			'{12'd518, 16'd0, 1'b1, 4'd0, 8'hFE, 8'h01, ST_OK}},
		'{'{{OP_ALU, 4'hF, 4'h0, ALU_SUB}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_ALU, 4'h2, 4'h0, ALU_SHR}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_ALU, 4'h3, 4'h0, ALU_SHL}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_ALU, 4'h4, 4'h0, ALU_SUBN}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_ALU, 4'h5, 4'h0, ALU_MOV}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_ALU, 4'h5, 4'h3, ALU_OR}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_ALU, 4'h5, 4'h0, ALU_AND}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_ALU, 4'h5, 4'h5, ALU_XOR}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_ADD, 4'h0, 8'hFF}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_SE, 4'h5, 8'h00}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_SNE, 4'h0, 8'h00}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_SER, 4'h5, 4'h6, 4'h0}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_SNER, 4'h5, 4'h6, 4'h1}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_RND, 4'h7, 8'hFF}, 8'hFF, 16'h0000}, 1'b0, '0},
		'{'{{OP_KEY, 4'h0, KEY_DOWN}, 8'h00, 16'hFFFF}, 1'b0, '0},
		'{'{{OP_KEY, 4'h0, KEY_UP}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_MISC, 4'h0, F_SET_DT}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_MISC, 4'h8, F_GET_DT}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_MISC, 4'h0, F_SET_ST}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_LDI, 12'hFFF}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_MISC, 4'h0, F_ADD_I}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_MISC, 4'h0, F_FONT}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_CALL, 12'hABC}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{RET_WORD, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_JPO, 12'hFFF}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_JP, 12'hFFF}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_MISC, 4'hF, 8'hFF}, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{{OP_SYS, 12'h000}, 8'h00, 16'h0000}, 1'b0, '0}
	};

	function automatic exec_result_t execute_instruction(instr_req_t r);
		exec_result_t res;
		logic [3:0]   op, x, y, n;
		logic [7:0]   nn, vx, vy, gpr_val, flag_val;
		logic [11:0]  nnn, pc;
		logic [8:0]   sum;
		logic [16:0]  wide_index;
		logic         gpr_wr, flag_wr;
		{op, x, y, n} = r.instr_word;
		nn = r.instr_word[7:0];
		nnn = r.instr_word[11:0];
		vx = vregs[x];
		vy = vregs[y];
		pc = cur_pc + 12'd2;
		res = '0;
		gpr_wr = 1'b0;
		flag_wr = 1'b0;
		gpr_val = 8'h00;
		flag_val = 8'h00;
		case (op)
		OP_SYS: begin
			if (r.instr_word != RET_WORD) res.status = ST_UNSUPPORTED;
			else if (stack_level == 0) res.status = ST_STACK;
			else begin
				stack_level--;
				pc = return_stack[stack_level];
			end
		end
		OP_JP: pc = nnn;
		OP_CALL: begin
			if (stack_level >= STACK_SLOTS) res.status = ST_STACK;
			else begin
				return_stack[stack_level] = pc;
				stack_level++;
				pc = nnn;
			end
		end
		OP_SE: if (vx == nn) pc += 12'd2;
		OP_SNE: if (vx != nn) pc += 12'd2;
		OP_SER: begin
			if (n != 4'h0) res.status = ST_UNSUPPORTED;
			else if (vx == vy) pc += 12'd2;
		end
		OP_SNER: begin
			if (n != 4'h0) res.status = ST_UNSUPPORTED;
			else if (vx != vy) pc += 12'd2;
		end
		OP_LD: begin
			gpr_wr = 1'b1;
			gpr_val = nn;
		end
		OP_ADD: begin
			gpr_wr = 1'b1;
			gpr_val = vx + nn;
		end
		OP_ALU: begin
			gpr_wr = 1'b1;
			case (n)
			ALU_MOV: gpr_val = vy;
			ALU_OR: gpr_val = vx | vy;
			ALU_AND: gpr_val = vx & vy;
			ALU_XOR: gpr_val = vx ^ vy;
			ALU_ADD: begin
				sum = {1'b0, vx} + {1'b0, vy};
				flag_wr = 1'b1;
				flag_val = {7'd0, sum[8]};
				gpr_val = sum[7:0];
			end
			ALU_SUB: begin
				flag_wr = 1'b1;
				flag_val = (vx >= vy) ? 8'd1 : 8'd0;
				gpr_val = vx - vy;
			end
			ALU_SHR: begin
				flag_wr = 1'b1;
				flag_val = {7'd0, vy[0]};
				gpr_val = vy >> 1;
			end
			ALU_SUBN: begin
				flag_wr = 1'b1;
				flag_val = (vy >= vx) ? 8'd1 : 8'd0;
				gpr_val = vy - vx;
			end
			ALU_SHL: begin
				flag_wr = 1'b1;
				flag_val = {7'd0, vy[7]};
				gpr_val = vy << 1;
			end
			default: begin
				gpr_wr = 1'b0;
				res.status = ST_UNSUPPORTED;
			end
			endcase
		end
		OP_LDI: index_reg = {4'd0, nnn};
		OP_JPO: pc = nnn + {4'd0, vx};
		OP_RND: begin
			gpr_wr = 1'b1;
			gpr_val = r.random_byte & nn;
		end
		OP_KEY: begin
			if (nn == KEY_DOWN) begin
				if (r.keys_down[vx[3:0]]) pc += 12'd2;
			end else if (nn == KEY_UP) begin
				if (!r.keys_down[vx[3:0]]) pc += 12'd2;
			end else res.status = ST_UNSUPPORTED;
		end
		OP_MISC: begin
			case (nn)
			F_GET_DT: begin
				gpr_wr = 1'b1;
				gpr_val = delay_count;
			end
			F_SET_DT: delay_count = vx;
			F_SET_ST: ; // sound timer is not visible at the outputs
			F_ADD_I: begin
				wide_index = {1'b0, index_reg} + {9'd0, vx};
				if (wide_index >= 17'h1000) begin
					flag_wr = 1'b1;
					flag_val = 8'd1;
				end
				index_reg = wide_index[15:0];
			end
			F_FONT: index_reg = FONT_BASE + {8'd0, vx} * 16'd5;
			default: res.status = ST_UNSUPPORTED;
			endcase
		end
		default: res.status = ST_UNSUPPORTED;
		endcase
		// flag goes first so a result in register 15 wins
		if (flag_wr) begin
			vregs[FLAG_REG] = flag_val;
			res.wrote_reg = 1'b1;
			res.reg_number = FLAG_REG;
			res.reg_value = flag_val;
		end
		if (gpr_wr) begin
			vregs[x] = gpr_val;
			res.wrote_reg = 1'b1;
			res.reg_number = x;
			res.reg_value = gpr_val;
		end
		cur_pc = pc;
		res.next_pc = pc;
		res.index_value = index_reg;
		res.flag_value = vregs[FLAG_REG];
		return res;
	endfunction

	function automatic instr_req_t random_request();
		instr_req_t r;
		logic [3:0] x, y;
		logic [7:0] nn;
		int         pick;
		x = 4'($urandom);
		y = 4'($urandom);
		nn = 8'($urandom);
		r.random_byte = 8'($urandom);
		r.keys_down = ($urandom_range(0, 7) == 0) ? {16{1'($urandom)}} : 16'($urandom);
		if (run_calls != 0) begin
			run_calls--;
			r.instr_word = {OP_CALL, 12'($urandom)};
			return r;
		end
		if (run_returns != 0) begin
			run_returns--;
			r.instr_word = RET_WORD;
			return r;
		end
		// now and then fill the stack to or past its end and unwind it past empty
		if ($urandom_range(0, 59) == 0) begin
			run_calls = STACK_SLOTS + $urandom_range(0, 2);
			run_returns = STACK_SLOTS + $urandom_range(1, 3);
		end
		pick = $urandom_range(0, 99);
		if (pick < 30)
			r.instr_word = {OP_ALU, x, y,
				($urandom_range(0, 9) == 0) ? 4'($urandom) : ALU_CODES[$urandom_range(0, 8)]};
		else if (pick < 40)
			r.instr_word = {$urandom_range(0, 1) ? OP_LD : OP_ADD, x, nn};
		else if (pick < 46)
			r.instr_word = {$urandom_range(0, 1) ? OP_SE : OP_SNE, x,
				$urandom_range(0, 1) ? vregs[x] : nn};
		else if (pick < 52) begin
			if ($urandom_range(0, 2) == 0) y = x;
			r.instr_word = {$urandom_range(0, 1) ? OP_SER : OP_SNER, x, y,
				($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h0};
		end else if (pick < 58)
			r.instr_word = {$urandom_range(0, 1) ? OP_JP : OP_JPO, 12'($urandom)};
		else if (pick < 66)
			r.instr_word = $urandom_range(0, 1) ? {OP_CALL, 12'($urandom)} : RET_WORD;
		else if (pick < 72)
			r.instr_word = {OP_LDI, $urandom_range(0, 1) ?
				12'($urandom_range(12'hF00, 12'hFFF)) : 12'($urandom)};
		else if (pick < 76)
			r.instr_word = {OP_RND, x, nn};
		else if (pick < 82)
			r.instr_word = {OP_KEY, x, ($urandom_range(0, 7) == 0) ? nn :
				($urandom_range(0, 1) ? KEY_DOWN : KEY_UP)};
		else if (pick < 94)
			r.instr_word = {OP_MISC, x,
				($urandom_range(0, 7) == 0) ? nn : MISC_CODES[$urandom_range(0, 4)]};
		else
			r.instr_word = 16'($urandom);
		return r;
	endfunction

	// entered and left at a falling edge
	task automatic send_request(input instr_req_t r, input logic typed,
		input exec_result_t want);
		exec_result_t predicted;
		if (burst_left == 0) begin
			instr_ch.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		burst_left--;
		instr_ch.valid = 1'b1;
		instr_ch.instr_word = r.instr_word;
		instr_ch.random_byte = r.random_byte;
		instr_ch.keys_down = r.keys_down;
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
		predicted = execute_instruction(r);
		expected_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	task automatic load_start_address(input logic [PC_W-1:0] addr);
		instr_ch.valid = 1'b0;
		wait_for_results();
		repeat (2) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = addr;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cur_pc = addr;
	endtask

	task automatic check_field(input string field, input int unsigned want, got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(64, 256);
		end
		mode_left--;
		if (stall_left != 0) begin
			result_ch.ready = 1'b0;
			stall_left--;
		end else begin
			result_ch.ready = 1'b1;
			if (stall_mode == 1 && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 3);
			else if (stall_mode == 2 && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(4, 30);
		end
	end

	always @(posedge clk) begin
		exec_result_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: result with no request pending, next_pc %0h", $time,
						result_ch.next_pc);
				end else begin
					want = expected_results.pop_front();
					check_field("next_pc", want.next_pc, result_ch.next_pc);
					check_field("index_value", want.index_value, result_ch.index_value);
					check_field("wrote_reg", want.wrote_reg, result_ch.wrote_reg);
					check_field("reg_number", want.reg_number, result_ch.reg_number);
					check_field("reg_value", want.reg_value, result_ch.reg_value);
					check_field("flag_value", want.flag_value, result_ch.flag_value);
					check_field("status", want.status, result_ch.status);
				end
			end
			if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("vm_instruction_execute_unit_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [PC_W-1:0] start_pc;
		instr_req_t      sweep;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		instr_ch.valid = 1'b0;
		instr_ch.instr_word = '0;
		instr_ch.random_byte = '0;
		instr_ch.keys_down = '0;
		result_ch.ready = 1'b0;
		foreach (vregs[i]) vregs[i] = '0;
		cur_pc = RESET_PC;
		index_reg = '0;
		stack_level = 0;
		delay_count = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
			0: start_pc = 12'hFFF;
			1: start_pc = 12'h000;
			4: start_pc = 12'hFFE;
			default: start_pc = 12'($urandom);
			endcase
			load_start_address(start_pc);
			if (phase == 2) begin
				// walk the index register up past its 16-bit wrap
				send_request('{{OP_LD, 4'hE, 8'hFF}, 8'h00, 16'h0000}, 1'b0, '0);
				send_request('{{OP_LDI, 12'hFFF}, 8'h00, 16'h0000}, 1'b0, '0);
				repeat (245) begin
					sweep = '{{OP_MISC, 4'hE, F_ADD_I}, 8'($urandom), 16'($urandom)};
					send_request(sweep, 1'b0, '0);
				end
			end
			repeat (90) send_request(random_request(), 1'b0, '0);
		end

		instr_ch.valid = 1'b0;
		wait_for_results();
		repeat (8) @(negedge clk);
		if (error_count == 0)
			$display("vm_instruction_execute_unit_tb: PASS");
		else
			$display("vm_instruction_execute_unit_tb: FAIL");
		$finish;
	end

endmodule
